// ===== rtl/patched_conic_delta_v_macros.svh =====
// Assertion shorthands used by the top-level design file.
`ifndef PATCHED_CONIC_DELTA_V_MACROS_SVH
`define PATCHED_CONIC_DELTA_V_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCDV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCDV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pcdv_pkg.sv =====
`timescale 1ns / 1ps
package pcdv_pkg;

    localparam int VEL_W     = 32;
    localparam int MU_W      = 38;
    localparam int RAD_W     = 24;
    localparam int ECC_W     = 17;
    localparam int K_W       = MU_W + 40;
    localparam int TWO_K_W   = K_W + 1;
    localparam int SQ_IN_W   = 80;
    localparam int ROOT_W    = SQ_IN_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int DV_W      = 32;
    localparam int CFG_IDX_W = 3;

    localparam int DIV_STEPS  = K_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int MUL_STEPS  = ECC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DEP_MU  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEP_RAD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARR_MU  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARR_RAD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ARR_ECC = 3'd4;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        logic [SQ_IN_W-1:0] rad;
    } t_sqrt_st;

    typedef struct packed {
        logic [TWO_K_W-1:0] two_k_dep;
        logic [ROOT_W-1:0]  sk_dep;
        logic [TWO_K_W-1:0] two_k_arr;
        logic [ROOT_W-1:0]  sk_cap;
        logic               direct;
    } t_cfg_terms;

    // One step of the digit-by-digit square root: two radicand bits in, one root bit out.
    function automatic t_sqrt_st sqrt_step(input t_sqrt_st s);
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        t_sqrt_st         o;
        cur   = {s.rem[REM_W-3:0], s.rad[SQ_IN_W-1 -: 2]};
        trial = {s.root, 2'b01};
        if (cur >= trial) begin
            o.rem  = cur - trial;
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = cur;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        o.rad = {s.rad[SQ_IN_W-3:0], 2'b00};
        return o;
    endfunction

endpackage

// ===== rtl/pcdv_sqrt_pipe.sv =====
`timescale 1ns / 1ps
module pcdv_sqrt_pipe (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [pcdv_pkg::SQ_IN_W-1:0] i_rad_dep,
    input  logic [pcdv_pkg::SQ_IN_W-1:0] i_rad_arr,
    output logic                         o_valid,
    output logic [pcdv_pkg::ROOT_W-1:0]  o_root_dep,
    output logic [pcdv_pkg::ROOT_W-1:0]  o_root_arr
);

    localparam int N = pcdv_pkg::SQRT_STEPS;

    pcdv_pkg::t_sqrt_st r_dep [N];
    pcdv_pkg::t_sqrt_st r_arr [N];
    logic               r_vld [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) r_vld[i] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < N; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dep[0] <= pcdv_pkg::sqrt_step('{rem: '0, root: '0, rad: i_rad_dep});
            r_arr[0] <= pcdv_pkg::sqrt_step('{rem: '0, root: '0, rad: i_rad_arr});
            for (int i = 1; i < N; i++) begin
                r_dep[i] <= pcdv_pkg::sqrt_step(r_dep[i-1]);
                r_arr[i] <= pcdv_pkg::sqrt_step(r_arr[i-1]);
            end
        end
    end

    assign o_valid    = r_vld[N-1];
    assign o_root_dep = r_dep[N-1].root;
    assign o_root_arr = r_arr[N-1].root;

endmodule

// ===== rtl/pcdv_cfg_unit.sv =====
`timescale 1ns / 1ps
module pcdv_cfg_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [pcdv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcdv_pkg::MU_W-1:0]      i_cfg_data,
    output pcdv_pkg::t_cfg_terms           o_terms,
    output logic                           o_busy
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_START    = 7'b0000010,
        S_DIV_DEP  = 7'b0000100,
        S_SQRT_DEP = 7'b0001000,
        S_DIV_ARR  = 7'b0010000,
        S_MUL_ARR  = 7'b0100000,
        S_SQRT_CAP = 7'b1000000
    } t_seq_state;

    localparam int KW   = pcdv_pkg::K_W;
    localparam int RW   = pcdv_pkg::RAD_W;
    localparam int EW   = pcdv_pkg::ECC_W;
    localparam int ACCW = KW + EW;

    t_seq_state r_state;
    logic [6:0] r_cnt;

    logic [pcdv_pkg::MU_W-1:0] r_dep_mu, r_arr_mu;
    logic [RW-1:0]             r_dep_r, r_arr_r;
    logic [EW-1:0]             r_arr_e;

    logic [KW-1:0]             r_quo;
    logic [RW-1:0]             r_drem;
    logic [RW-1:0]             r_div;
    pcdv_pkg::t_sqrt_st        r_sq;
    logic [ACCW-1:0]           r_acc;
    logic [EW-1:0]             r_mult;
    logic [KW-1:0]             r_k_dep, r_k_arr;
    logic [pcdv_pkg::ROOT_W-1:0] r_sk_dep, r_sk_cap;

    logic [RW:0]               n_dshift;
    logic                      n_dge;
    logic [RW-1:0]             n_drem;
    logic [KW-1:0]             n_quo;
    pcdv_pkg::t_sqrt_st        n_sq;
    logic [ACCW-1:0]           n_acc;
    logic [RW-1:0]             n_div_dep, n_div_arr;

    always_comb begin
        n_dshift  = {r_drem, r_quo[KW-1]};
        n_dge     = n_dshift >= {1'b0, r_div};
        n_drem    = n_dge ? RW'(n_dshift - {1'b0, r_div}) : n_dshift[RW-1:0];
        n_quo     = {r_quo[KW-2:0], n_dge};
        n_sq      = pcdv_pkg::sqrt_step(r_sq);
        n_acc     = {r_acc[ACCW-2:0], 1'b0} + (r_mult[EW-1] ? {{EW{1'b0}}, r_k_arr} : '0);
        // A zero radius is taken as one kilometre.
        n_div_dep = (r_dep_r == '0) ? RW'(1) : r_dep_r;
        n_div_arr = (r_arr_r == '0) ? RW'(1) : r_arr_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dep_mu <= pcdv_pkg::MU_W'(398600);
            r_dep_r  <= RW'(6678);
            r_arr_mu <= pcdv_pkg::MU_W'(42828);
            r_arr_r  <= RW'(3790);
            r_arr_e  <= '0;
            r_state  <= S_START;
            r_cnt    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pcdv_pkg::CFG_DEP_MU:  r_dep_mu <= i_cfg_data;
                pcdv_pkg::CFG_DEP_RAD: r_dep_r  <= i_cfg_data[RW-1:0];
                pcdv_pkg::CFG_ARR_MU:  r_arr_mu <= i_cfg_data;
                pcdv_pkg::CFG_ARR_RAD: r_arr_r  <= i_cfg_data[RW-1:0];
                pcdv_pkg::CFG_ARR_ECC: r_arr_e  <= i_cfg_data[EW-1:0];
                default: ;
            endcase
            r_state <= S_START;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_START: begin
                    r_quo   <= {r_dep_mu, 40'b0};
                    r_drem  <= '0;
                    r_div   <= n_div_dep;
                    r_cnt   <= '0;
                    r_state <= S_DIV_DEP;
                end
                S_DIV_DEP: begin
                    r_quo  <= n_quo;
                    r_drem <= n_drem;
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_cnt == 7'(pcdv_pkg::DIV_STEPS - 1)) begin
                        r_k_dep <= n_quo;
                        r_sq    <= '{rem: '0, root: '0, rad: {2'b00, n_quo}};
                        r_cnt   <= '0;
                        r_state <= S_SQRT_DEP;
                    end
                end
                S_SQRT_DEP: begin
                    r_sq  <= n_sq;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'(pcdv_pkg::SQRT_STEPS - 1)) begin
                        r_sk_dep <= n_sq.root;
                        r_quo    <= {r_arr_mu, 40'b0};
                        r_drem   <= '0;
                        r_div    <= n_div_arr;
                        r_cnt    <= '0;
                        r_state  <= S_DIV_ARR;
                    end
                end
                S_DIV_ARR: begin
                    r_quo  <= n_quo;
                    r_drem <= n_drem;
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_cnt == 7'(pcdv_pkg::DIV_STEPS - 1)) begin
                        r_k_arr <= n_quo;
                        r_acc   <= '0;
                        r_mult  <= {1'b1, r_arr_e[EW-2:0]};
                        r_cnt   <= '0;
                        r_state <= S_MUL_ARR;
                    end
                end
                S_MUL_ARR: begin
                    r_acc  <= n_acc;
                    r_mult <= {r_mult[EW-2:0], 1'b0};
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_cnt == 7'(pcdv_pkg::MUL_STEPS - 1)) begin
                        // Dropping sixteen bits scales by one plus the Q0.16 eccentricity.
                        r_sq    <= '{rem: '0, root: '0, rad: {1'b0, n_acc[ACCW-1:16]}};
                        r_cnt   <= '0;
                        r_state <= S_SQRT_CAP;
                    end
                end
                S_SQRT_CAP: begin
                    r_sq  <= n_sq;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'(pcdv_pkg::SQRT_STEPS - 1)) begin
                        r_sk_cap <= n_sq.root;
                        r_state  <= S_IDLE;
                    end
                end
                S_IDLE: ;
                default: r_state <= S_START;
            endcase
        end
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_terms.two_k_dep = {r_k_dep, 1'b0};
    assign o_terms.sk_dep    = r_sk_dep;
    assign o_terms.two_k_arr = {r_k_arr, 1'b0};
    assign o_terms.sk_cap    = r_sk_cap;
    assign o_terms.direct    = r_arr_e[EW-1];

endmodule

// ===== rtl/patched_conic_delta_v.sv =====
`timescale 1ns / 1ps
// Patched-conic departure and arrival burn calculator.
// Input channel (i_in_valid / o_in_ready): one word holds the craft and planet
// velocities at departure and arrival, signed Q11.20 km/s.
// Output channel (o_out_valid / i_out_ready): one word per input word with the
// departure, arrival and total burns in unsigned Q12.20 km/s and a saturation flag.
// Configuration channel (i_cfg_valid / o_cfg_ready): register index and data;
// the port is always ready.
// The result word passes the difference, square and radicand registers, a 40-stage
// square root pipeline per leg, and the leg and output registers. Throughput is one
// word per cycle while o_in_ready is high. The per-body terms mu/r, sqrt(mu/r) and
// the capture speed are worked out by a serial divider, multiplier and root unit
// after reset and every configuration write; o_in_ready stays low during that time.
// Reset restores the default Earth and Mars parameters and empties the pipeline.
// When the receiver stalls, the whole pipeline holds and o_in_ready drops with it;
// no word is lost or repeated.
`include "patched_conic_delta_v_macros.svh"
module patched_conic_delta_v (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pcdv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcdv_pkg::MU_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [31:0]             i_dep_craft_vx,
    input  logic signed [31:0]             i_dep_craft_vy,
    input  logic signed [31:0]             i_dep_craft_vz,
    input  logic signed [31:0]             i_dep_body_vx,
    input  logic signed [31:0]             i_dep_body_vy,
    input  logic signed [31:0]             i_dep_body_vz,
    input  logic signed [31:0]             i_arr_craft_vx,
    input  logic signed [31:0]             i_arr_craft_vy,
    input  logic signed [31:0]             i_arr_craft_vz,
    input  logic signed [31:0]             i_arr_body_vx,
    input  logic signed [31:0]             i_arr_body_vy,
    input  logic signed [31:0]             i_arr_body_vz,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [31:0]                    o_departure_dv,
    output logic [31:0]                    o_arrival_dv,
    output logic [31:0]                    o_total_dv,
    output logic                           o_saturated
);

    localparam int RW = pcdv_pkg::ROOT_W;
    localparam int SW = pcdv_pkg::SQ_IN_W;

    pcdv_pkg::t_cfg_terms w_terms;
    logic                 w_busy;
    logic                 w_en;

    logic signed [31:0] w_a [6];
    logic signed [31:0] w_b [6];
    logic signed [32:0] w_diff [6];

    logic        r_v1, r_v2, r_v3, r_v4;
    logic [31:0] r_d  [6];
    logic [63:0] r_sq [6];
    logic [SW-1:0] r_rad_dep, r_rad_arr;

    logic          w_sv;
    logic [RW-1:0] w_root_dep, w_root_arr;

    logic [RW-1:0] r_leg_dep, r_leg_arr;
    logic [RW:0]   w_total;
    logic          w_sat_dep, w_sat_arr, w_sat_tot;

    logic          r_out_valid;
    logic [31:0]   r_dep_out, r_arr_out, r_tot_out;
    logic          r_sat;

    pcdv_cfg_unit u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_terms     (w_terms),
        .o_busy      (w_busy)
    );

    assign w_en        = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_en && !w_busy;
    assign o_cfg_ready = 1'b1;

    assign w_a[0] = i_dep_craft_vx;  assign w_b[0] = i_dep_body_vx;
    assign w_a[1] = i_dep_craft_vy;  assign w_b[1] = i_dep_body_vy;
    assign w_a[2] = i_dep_craft_vz;  assign w_b[2] = i_dep_body_vz;
    assign w_a[3] = i_arr_craft_vx;  assign w_b[3] = i_arr_body_vx;
    assign w_a[4] = i_arr_craft_vy;  assign w_b[4] = i_arr_body_vy;
    assign w_a[5] = i_arr_craft_vz;  assign w_b[5] = i_arr_body_vz;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_diff[i] = 33'(w_a[i]) - 33'(w_b[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid && o_in_ready;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 6; i++) begin
                r_d[i]  <= w_diff[i][32] ? 32'(-w_diff[i]) : w_diff[i][31:0];
                r_sq[i] <= 64'(r_d[i]) * 64'(r_d[i]);
            end
            // Squared excess speed plus 2mu/r, all in Q.40.
            r_rad_dep <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2])
                       + SW'(w_terms.two_k_dep);
            r_rad_arr <= SW'(r_sq[3]) + SW'(r_sq[4]) + SW'(r_sq[5])
                       + SW'(w_terms.two_k_arr);
        end
    end

    pcdv_sqrt_pipe u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_v3),
        .i_rad_dep  (r_rad_dep),
        .i_rad_arr  (r_rad_arr),
        .o_valid    (w_sv),
        .o_root_dep (w_root_dep),
        .o_root_arr (w_root_arr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v4        <= w_sv;
            r_out_valid <= r_v4;
        end
    end

    assign w_total   = {1'b0, r_leg_dep} + {1'b0, r_leg_arr};
    assign w_sat_dep = |r_leg_dep[RW-1:32];
    assign w_sat_arr = |r_leg_arr[RW-1:32];
    assign w_sat_tot = |w_total[RW:32];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_leg_dep <= (w_root_dep > w_terms.sk_dep) ? w_root_dep - w_terms.sk_dep : '0;
            // Direct entry needs no capture burn.
            r_leg_arr <= (!w_terms.direct && (w_root_arr > w_terms.sk_cap))
                       ? w_root_arr - w_terms.sk_cap : '0;
            r_dep_out <= w_sat_dep ? '1 : r_leg_dep[31:0];
            r_arr_out <= w_sat_arr ? '1 : r_leg_arr[31:0];
            r_tot_out <= w_sat_tot ? '1 : w_total[31:0];
            r_sat     <= w_sat_dep || w_sat_arr || w_sat_tot;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_departure_dv = r_dep_out;
    assign o_arrival_dv   = r_arr_out;
    assign o_total_dv     = r_tot_out;
    assign o_saturated    = r_sat;

    `PCDV_ASSERT_NOW(a_busy_blocks_input, w_busy, !o_in_ready, "input taken while precomputing")
    `PCDV_ASSERT_NEXT(a_cfg_restarts, i_cfg_valid, w_busy, "config write did not restart precompute")
    `PCDV_ASSERT_NOW(a_direct_zero, o_out_valid && w_terms.direct, o_arrival_dv == '0, "direct entry gave a capture burn")
    `PCDV_ASSERT_NOW(a_total_sum, o_out_valid && !o_saturated, {1'b0, o_total_dv} == {1'b0, o_departure_dv} + {1'b0, o_arrival_dv}, "total is not the sum of the legs")

endmodule
